@@ rtl/core/lzd_pkg.sv @@
// Package for the LZ window decompressor: word types, phase and status codes,
// length/distance split function. No dependencies.
package lzd_pkg;

    localparam int WIN_AW     = 12;
    localparam int COPY_BURST = 64;
    localparam int BURST_W    = 7;
    localparam int LEFT_W     = 13;
    localparam int SKIP_W     = 33;
    localparam int ADDR_W     = 3;

    localparam logic [2:0] PH_SKIP  = 3'd0;
    localparam logic [2:0] PH_FLAG  = 3'd1;
    localparam logic [2:0] PH_ELEM  = 3'd2;
    localparam logic [2:0] PH_TOKHI = 3'd3;
    localparam logic [2:0] PH_HDRHI = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    localparam logic [1:0] ST_BYTE    = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_CONT = 1'b1;

    localparam logic [ADDR_W-1:0] REG_START_OFFSET = 3'd0;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       copy_pending;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic        en;
        logic [31:0] value;
    } t_cfg_wr;

    function automatic logic [3:0] split_for(input logic [WIN_AW-1:0] wp);
        logic [3:0] sh;
        begin
            if (wp <= 12'h010)      sh = 4'd12;
            else if (wp <= 12'h020) sh = 4'd11;
            else if (wp <= 12'h040) sh = 4'd10;
            else if (wp <= 12'h080) sh = 4'd9;
            else if (wp <= 12'h100) sh = 4'd8;
            else if (wp <= 12'h200) sh = 4'd7;
            else if (wp <= 12'h400) sh = 4'd6;
            else if (wp <= 12'h800) sh = 4'd5;
            else                    sh = 4'd4;
            return sh;
        end
    endfunction

endpackage

@@ rtl/core/lzd_window.sv @@
// History window: 4096 x 8 single write port, registered read port.
// Depends on lzd_pkg.
module lzd_window (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [lzd_pkg::WIN_AW-1:0] i_waddr,
    input  logic [7:0]                 i_wdata,
    input  logic                       i_re,
    input  logic [lzd_pkg::WIN_AW-1:0] i_raddr,
    output logic [7:0]                 o_rdata
);
    logic [7:0] r_mem [0:(1 << lzd_pkg::WIN_AW)-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/lzd_seq.sv @@
// Decode sequencer: parses flag/literal/token words and drives the window
// copy loop one byte at a time. Depends on lzd_pkg, lzd_window.
module lzd_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  lzd_pkg::t_in_word   i_in,
    input  lzd_pkg::t_cfg_wr    i_cfg,
    input  logic                i_res_free,
    output logic                o_ready,
    output logic                o_res_valid,
    output lzd_pkg::t_out_word  o_res
);
    localparam logic [2:0] SQ_IDLE = 3'd0;
    localparam logic [2:0] SQ_EMIT = 3'd1;
    localparam logic [2:0] SQ_RD   = 3'd2;
    localparam logic [2:0] SQ_CP   = 3'd3;
    localparam logic [2:0] SQ_END  = 3'd4;

    logic [2:0]                   r_sq, n_sq;
    logic [2:0]                   r_phase, n_phase;
    logic [lzd_pkg::WIN_AW-1:0]   r_wpos, n_wpos;
    logic                         r_wrapped, n_wrapped;
    logic                         r_any, n_any;
    logic [7:0]                   r_flags, n_flags;
    logic [3:0]                   r_bidx, n_bidx;
    logic [7:0]                   r_toklo, n_toklo;
    logic                         r_clean, n_clean;
    logic [lzd_pkg::LEFT_W-1:0]   r_cleft, n_cleft;
    logic [lzd_pkg::WIN_AW-1:0]   r_cdist, n_cdist;
    logic [lzd_pkg::SKIP_W-1:0]   r_skip, n_skip;
    logic                         r_end, n_end;
    lzd_pkg::t_out_word           r_res, n_res;
    logic                         r_res_end, n_res_end;
    logic [lzd_pkg::BURST_W-1:0]  r_burst, n_burst;
    logic                         r_lim63, n_lim63;
    logic                         r_tail, n_tail;
    logic                         r_rvalid, n_rvalid;

    logic                         we, re;
    logic [7:0]                   wdata, rdata;
    logic [lzd_pkg::WIN_AW-1:0]   raddr;
    logic [15:0]                  tok;
    logic [3:0]                   sh;
    logic [lzd_pkg::LEFT_W-1:0]   left;
    logic [lzd_pkg::BURST_W-1:0]  cnt, lim;
    logic                         more, tail_now, emit_lit;
    logic [7:0]                   cbyte;

    lzd_window u_win (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_wpos),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_ready = (r_sq == SQ_IDLE);
    assign raddr   = r_wpos - r_cdist - 12'd1;
    assign tok     = {i_in.data_byte, r_toklo};
    assign sh      = lzd_pkg::split_for(r_wpos);
    assign cbyte   = r_rvalid ? rdata : 8'd0;

    always_comb begin
        n_sq = r_sq; n_phase = r_phase; n_wpos = r_wpos; n_wrapped = r_wrapped;
        n_any = r_any; n_flags = r_flags; n_bidx = r_bidx; n_toklo = r_toklo;
        n_clean = r_clean; n_cleft = r_cleft; n_cdist = r_cdist; n_skip = r_skip;
        n_end = r_end; n_res = r_res; n_res_end = r_res_end; n_burst = r_burst;
        n_lim63 = r_lim63; n_tail = r_tail; n_rvalid = r_rvalid;
        we = 1'b0; re = 1'b0; wdata = i_in.data_byte;
        o_res_valid = 1'b0; o_res = r_res;
        emit_lit = 1'b0;
        left = r_cleft - 13'd1;
        cnt  = r_burst + 7'd1;
        lim  = r_lim63 ? 7'(lzd_pkg::COPY_BURST - 1) : 7'(lzd_pkg::COPY_BURST);
        more = 1'b0; tail_now = 1'b0;

        case (r_sq)
            SQ_IDLE: begin
                if (i_acc) begin
                    if (i_in.command == lzd_pkg::CMD_CONT) begin
                        if (r_cleft != '0) begin
                            n_burst = '0;
                            n_lim63 = r_end;
                            n_tail  = r_end && (r_phase != lzd_pkg::PH_DONE);
                            n_sq    = SQ_RD;
                        end
                    end else if (r_cleft != '0) begin
                        n_res     = '{8'd0, lzd_pkg::ST_REFUSED, 1'b1, 1'b1};
                        n_res_end = 1'b0;
                        n_sq      = SQ_EMIT;
                    end else if (!r_end) begin
                        case (r_phase)
                            lzd_pkg::PH_SKIP: begin
                                if (r_skip != '0) n_skip = r_skip - 33'd1;
                                if (n_skip == '0) n_phase = lzd_pkg::PH_FLAG;
                            end
                            lzd_pkg::PH_FLAG: begin
                                n_flags = i_in.data_byte;
                                n_bidx  = 4'd0;
                                n_phase = lzd_pkg::PH_ELEM;
                            end
                            lzd_pkg::PH_ELEM: begin
                                if (r_flags[r_bidx[2:0]]) begin
                                    n_toklo = i_in.data_byte;
                                    n_phase = lzd_pkg::PH_TOKHI;
                                end else if (r_any && r_wpos == '0 && r_clean) begin
                                    n_phase = lzd_pkg::PH_HDRHI;
                                end else begin
                                    we        = 1'b1;
                                    n_wpos    = r_wpos + 12'd1;
                                    n_wrapped = r_wrapped | (&r_wpos);
                                    n_any     = 1'b1;
                                    n_clean   = 1'b1;
                                    n_bidx    = r_bidx + 4'd1;
                                    n_phase   = (n_bidx >= 4'd8) ? lzd_pkg::PH_FLAG
                                                                 : lzd_pkg::PH_ELEM;
                                    emit_lit  = 1'b1;
                                    n_res     = '{i_in.data_byte, lzd_pkg::ST_BYTE, 1'b0,
                                                  !i_in.end_of_stream};
                                    n_res_end = 1'b0;
                                    n_sq      = SQ_EMIT;
                                end
                            end
                            lzd_pkg::PH_TOKHI: begin
                                n_cleft = 13'(({4'd0, tok[11:0]}
                                          & ((16'd1 << sh) - 16'd1)) + 16'd3);
                                n_cdist = 12'(tok >> sh);
                                n_clean = 1'b1;
                                n_bidx  = r_bidx + 4'd1;
                                n_phase = (n_bidx >= 4'd8) ? lzd_pkg::PH_FLAG
                                                           : lzd_pkg::PH_ELEM;
                                n_burst = '0;
                                n_lim63 = 1'b0;
                                n_tail  = i_in.end_of_stream;
                                n_sq    = SQ_RD;
                            end
                            lzd_pkg::PH_HDRHI: begin
                                n_clean = 1'b0;
                                n_bidx  = 4'd8;
                                n_phase = lzd_pkg::PH_FLAG;
                            end
                            default: begin
                            end
                        endcase
                        if (i_in.end_of_stream) begin
                            n_end = 1'b1;
                            if (n_phase == lzd_pkg::PH_TOKHI || n_phase == lzd_pkg::PH_HDRHI) begin
                                n_res   = '{8'd0, lzd_pkg::ST_TRUNC, 1'b0, 1'b1};
                                n_phase = lzd_pkg::PH_DONE;
                                n_sq    = SQ_EMIT;
                            end else if (r_phase != lzd_pkg::PH_TOKHI) begin
                                n_phase = lzd_pkg::PH_DONE;
                                if (emit_lit) begin
                                    n_res_end = 1'b1;
                                end else begin
                                    n_res = '{8'd0, lzd_pkg::ST_END, 1'b0, 1'b1};
                                    n_sq  = SQ_EMIT;
                                end
                            end
                        end
                    end
                end
            end
            SQ_EMIT: begin
                if (i_res_free) begin
                    o_res_valid = 1'b1;
                    if (r_res_end) begin
                        n_res     = '{8'd0, lzd_pkg::ST_END, 1'b0, 1'b1};
                        n_res_end = 1'b0;
                    end else begin
                        n_sq = SQ_IDLE;
                    end
                end
            end
            SQ_RD: begin
                re       = 1'b1;
                n_rvalid = r_wrapped || (raddr < r_wpos);
                n_sq     = SQ_CP;
            end
            SQ_CP: begin
                if (i_res_free) begin
                    more        = (left != '0) && (cnt < lim);
                    tail_now    = r_tail && (left == '0);
                    we          = 1'b1;
                    wdata       = cbyte;
                    n_wpos      = r_wpos + 12'd1;
                    n_wrapped   = r_wrapped | (&r_wpos);
                    n_any       = 1'b1;
                    n_cleft     = left;
                    n_burst     = cnt;
                    o_res_valid = 1'b1;
                    o_res       = '{cbyte, lzd_pkg::ST_BYTE, left != '0, !more && !tail_now};
                    if (more) begin
                        n_sq = SQ_RD;
                    end else if (tail_now) begin
                        n_phase = lzd_pkg::PH_DONE;
                        n_sq    = SQ_END;
                    end else begin
                        n_sq = SQ_IDLE;
                    end
                end
            end
            SQ_END: begin
                o_res = '{8'd0, lzd_pkg::ST_END, 1'b0, 1'b1};
                if (i_res_free) begin
                    o_res_valid = 1'b1;
                    n_sq        = SQ_IDLE;
                end
            end
            default: n_sq = SQ_IDLE;
        endcase

        if (i_cfg.en && r_phase == lzd_pkg::PH_SKIP && !r_end) begin
            n_skip = {1'b0, i_cfg.value} + 33'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= SQ_IDLE; r_phase <= lzd_pkg::PH_SKIP; r_wpos <= '0;
            r_wrapped <= 1'b0; r_any <= 1'b0; r_flags <= '0; r_bidx <= 4'd8;
            r_toklo <= '0; r_clean <= 1'b1; r_cleft <= '0; r_cdist <= '0;
            r_skip <= 33'd3; r_end <= 1'b0; r_res_end <= 1'b0;
            r_burst <= '0; r_lim63 <= 1'b0; r_tail <= 1'b0; r_rvalid <= 1'b0;
        end else begin
            r_sq <= n_sq; r_phase <= n_phase; r_wpos <= n_wpos;
            r_wrapped <= n_wrapped; r_any <= n_any; r_flags <= n_flags; r_bidx <= n_bidx;
            r_toklo <= n_toklo; r_clean <= n_clean; r_cleft <= n_cleft; r_cdist <= n_cdist;
            r_skip <= n_skip; r_end <= n_end; r_res_end <= n_res_end;
            r_burst <= n_burst; r_lim63 <= n_lim63; r_tail <= n_tail; r_rvalid <= n_rvalid;
        end
        r_res <= n_res;
    end
endmodule

@@ rtl/core/ovba_lz_decompressor_top.sv @@
// Top level of the LZ window decompressor: APB register, output register.
// Depends on lzd_pkg, lzd_seq.
//
// One compressed byte per input word. Skipped, flag, literal and header words
// are taken in the idle state; each result passes through the output register.
// A copy token or continue word emits at most 64 bytes, each through a read
// state and then a copy state, as the 4096-byte window memory has a single
// read/write port pair. The input stall stays high until every result of a
// word has entered the output register. The window needs no clearing pass
// after reset: a fill mark makes bytes never written read as zero.
module ovba_lz_decompressor_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  lzd_pkg::t_in_word           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lzd_pkg::t_out_word          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lzd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    logic               ready, acc, res_valid, res_free;
    lzd_pkg::t_out_word res;
    lzd_pkg::t_cfg_wr   cfg;
    logic [31:0]        r_start_offset;
    logic               r_out_valid;
    lzd_pkg::t_out_word r_out;

    assign pready     = 1'b1;
    assign cfg.en     = psel && penable && pwrite && (paddr == lzd_pkg::REG_START_OFFSET);
    assign cfg.value  = pwdata;
    assign prdata     = (paddr == lzd_pkg::REG_START_OFFSET) ? r_start_offset : 32'd0;
    assign o_in_stall = !ready;
    assign acc        = i_in_valid && ready;
    assign res_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg.en) r_start_offset <= pwdata;
            if (res_free) r_out_valid <= res_valid;
        end
        if (res_free && res_valid) r_out <= res;
    end

    lzd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_in       (i_in_data),
        .i_cfg      (cfg),
        .i_res_free (res_free),
        .o_ready    (ready),
        .o_res_valid(res_valid),
        .o_res      (res)
    );
endmodule

@@ rtl/core/lzd_checker.sv @@
// Port-level checks for the decompressor top; bound to it below.
// Depends on lzd_pkg.
module lzd_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lzd_pkg::t_out_word o_out_data,
    input logic               pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed under stall");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != lzd_pkg::ST_BYTE |-> o_out_data.out_byte == 8'd0)
        else $error("status word carries a byte");

    a_endlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == lzd_pkg::ST_END ||
                        o_out_data.status == lzd_pkg::ST_TRUNC)
        |-> o_out_data.last && !o_out_data.copy_pending)
        else $error("end word not final");

    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == lzd_pkg::ST_REFUSED
        |-> o_out_data.last && o_out_data.copy_pending)
        else $error("refused word malformed");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind ovba_lz_decompressor_top lzd_port_checks u_lzd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data),
    .pready     (pready)
);
